>>> rtl/bic_pkg.sv
`default_nettype none
package bic_pkg;

    // field geometry
    localparam int ROWS      = 256;
    localparam int ROW_BYTES = 32;
    localparam int LOG_SIZE  = 8;
    localparam int NSCALES   = LOG_SIZE + 1;

    // payload widths
    localparam int CELL_W  = 8;
    localparam int SCALE_W = 4;
    localparam int CNT_W   = 17;
    localparam int IN_W    = ((CELL_W + 7) / 8) * 8;
    localparam int OUT_W   = ((SCALE_W + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // position counters and indexes
    localparam int BP_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int RP_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = (NSCALES > 1) ? $clog2(NSCALES) : 1;

    // one lane sees up to eight box groups of one byte
    localparam int GRP_W = CELL_W;
    localparam int INC_W = $clog2(GRP_W + 1);

    // masks of the cell pairs and nibbles of a byte
    localparam logic [CELL_W-1:0] PAIR_MASK   = 8'h03;
    localparam logic [CELL_W-1:0] NIBBLE_MASK = 8'h0F;

    // boxes per byte that keep a flag: pairs, nibbles, then one box end
    function automatic int flag_cnt(input int s);
        int n;
        if (s == 0) begin
            n = 0;
        end else if (s == 1) begin
            n = 4;
        end else if (s == 2) begin
            n = 2;
        end else begin
            n = 1;
        end
        return n;
    endfunction

    function automatic int flag_off(input int s);
        int n;
        n = 0;
        for (int j = 1; j < s; j++) begin
            n += flag_cnt(j);
        end
        return n;
    endfunction

    localparam int FLAG_BITS = flag_off(NSCALES);
    localparam int FLAG_W    = (FLAG_BITS > 0) ? FLAG_BITS : 1;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [NSCALES-1:0][CNT_W-1:0] t_count_vec;

    typedef struct packed {
        logic [GRP_W-1:0] occ;    // groups holding a set cell
        logic [GRP_W-1:0] en;     // groups that close this beat
        logic [GRP_W-1:0] old;    // stored flags of the groups
        logic             fresh;  // first row of a band: stored flags void
    } t_lane_in;

endpackage
`default_nettype wire

>>> rtl/bic_lane.sv
`default_nettype none
module bic_lane (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic             i_clear,
    input  wire bic_pkg::t_lane_in i_grp,
    output logic [bic_pkg::GRP_W-1:0] o_flags,
    output bic_pkg::t_count       o_total
);
    import bic_pkg::*;

    logic [GRP_W-1:0] eff_old;
    logic [GRP_W-1:0] hit;
    logic [INC_W-1:0] inc;
    logic [CNT_W:0]   sum;
    t_count           r_count;
    t_count           n_count;

    always_comb begin
        eff_old = i_grp.fresh ? '0 : i_grp.old;
        hit     = i_grp.occ & i_grp.en & ~eff_old;
        o_flags = eff_old | (i_grp.occ & i_grp.en);
        inc     = '0;
        for (int i = 0; i < GRP_W; i++) begin
            inc = inc + INC_W'(hit[i]);
        end
        sum     = {1'b0, r_count} + (CNT_W + 1)'(inc);
        // saturate at the top of the count range
        n_count = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
    end

    assign o_total = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= i_clear ? '0 : n_count;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bic_emit.sv
`default_nettype none
module bic_emit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire bic_pkg::t_count_vec   i_counts,
    output logic                       o_free,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [bic_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                       o_m_tlast
);
    import bic_pkg::*;

    t_count_vec         r_cnt;
    logic               r_busy;
    logic [SCALE_W-1:0] r_idx;
    logic               beat;

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = (r_idx == SCALE_W'(LOG_SIZE));
    assign beat       = r_busy && i_m_tready;
    assign o_free     = !r_busy || (beat && o_m_tlast);
    assign o_m_tdata  = {{(OUT_W - SCALE_W - CNT_W){1'b0}}, r_cnt[r_idx[IDX_W-1:0]], r_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (beat) begin
            if (o_m_tlast) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt <= i_counts;
        end
    end

endmodule
`default_nettype wire

>>> rtl/binary_image_box_count.sv
`default_nettype none
// Box counter for a bit-packed binary field. Bytes arrive in raster order on the
// slave stream, ROW_BYTES per row and ROWS rows, bit 0 the leftmost cell. One byte
// is taken every clock cycle: a beat is registered together with the flag row of
// its column, read from a ROW_BYTES-deep flag memory at the same edge, and from
// these registers all scale lanes update their flags and counts in parallel while
// the following byte is already read. The memory has one read and one write port;
// a write to the row being read is forwarded, so back-to-back beats do not stall on it.
// Flags of a band are voided by the row position rather than cleared, so there is
// no clearing pass after reset. Box sizes of 8 cells and more collect one row of
// their box with a running or and check their flag at the box end. After the
// last byte of a field the counts are copied to an output buffer and the master
// stream shows LOG_SIZE+1 beats, smallest box first, tlast on the largest; the
// next field starts right away. The slave side only stalls when a field ends
// while the results of the previous field have not all been taken.
module binary_image_box_count (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [bic_pkg::IN_W-1:0]   i_s_tdata,   // [7:0] cell_byte
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [bic_pkg::OUT_W-1:0]       o_m_tdata,   // [3:0] scale_log, [20:4] box_count
    output logic                            o_m_tlast    // last_of_run
);
    import bic_pkg::*;

    // raster position of the next beat
    logic [BP_W-1:0]   r_byte_pos;
    logic [RP_W-1:0]   r_row_pos;
    logic              in_fire;
    logic              in_row_end;
    logic              in_eof;
    logic [NSCALES-1:0] in_fresh;

    // update stage
    logic               r_a_valid;
    logic [CELL_W-1:0]  r_a_byte;
    logic [BP_W-1:0]    r_a_pos;
    logic [NSCALES-1:0] r_a_fresh;
    logic               r_a_row_end;
    logic               r_a_eof;
    logic               a_fire;
    logic               a_any;
    logic [NSCALES-1:0] box_end;
    logic [NSCALES-1:0] r_or;

    // flag memory, one row per byte column
    logic [FLAG_W-1:0]  r_mem [ROW_BYTES];
    logic [FLAG_W-1:0]  r_rd;
    logic [FLAG_W-1:0]  wdata;

    // lanes and merge
    t_lane_in                       lin [NSCALES];
    logic [NSCALES-1:0][GRP_W-1:0]  lane_flags;
    t_count_vec                     totals;
    logic                           emit_free;

    // first row of a band of 2^s rows: low s bits of the row are zero
    function automatic logic band_first(input logic [RP_W-1:0] row, input int s);
        logic r;
        r = 1'b1;
        for (int i = 0; i < RP_W; i++) begin
            if (i < s && row[i]) begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign in_row_end = (r_byte_pos == BP_W'(ROW_BYTES - 1));
    assign in_eof     = in_row_end && (r_row_pos == RP_W'(ROWS - 1));
    assign a_fire     = r_a_valid && (!r_a_eof || emit_free);
    assign o_s_tready = !r_a_valid || a_fire;
    assign a_any      = |r_a_byte;

    always_comb begin
        for (int s = 0; s < NSCALES; s++) begin
            in_fresh[s] = band_first(r_row_pos, s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_row_pos  <= '0;
        end else if (in_fire) begin
            if (in_row_end) begin
                r_byte_pos <= '0;
                r_row_pos  <= in_eof ? '0 : r_row_pos + 1'b1;
            end else begin
                r_byte_pos <= r_byte_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_byte    <= i_s_tdata[CELL_W-1:0];
            r_a_pos     <= r_byte_pos;
            r_a_fresh   <= in_fresh;
            r_a_row_end <= in_row_end;
            r_a_eof     <= in_eof;
        end
    end

    // memory: read ahead for the incoming beat, write back on update,
    // forward the write when both hit the same column
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_mem[r_a_pos] <= wdata;
        end
        if (in_fire) begin
            if (a_fire && (r_a_pos == r_byte_pos)) begin
                r_rd <= wdata;
            end else begin
                r_rd <= r_mem[r_byte_pos];
            end
        end
    end

    // a box of 2^s cells (s >= 3) closes at its last byte in the row
    always_comb begin
        logic [BP_W-1:0] m;
        m = '0;
        for (int s = 0; s < NSCALES; s++) begin
            if (s < 3) begin
                box_end[s] = 1'b1;
            end else begin
                m          = BP_W'((64'(1) << (s - 3)) - 64'(1));
                box_end[s] = ((r_a_pos & m) == m) || r_a_row_end;
            end
        end
    end

    // running or of the current row's bytes inside an open box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_or <= '0;
        end else if (a_fire) begin
            for (int s = 0; s < NSCALES; s++) begin
                if (s < 3 || box_end[s]) begin
                    r_or[s] <= 1'b0;
                end else begin
                    r_or[s] <= r_or[s] | a_any;
                end
            end
        end
    end

    // lane inputs: single cells, cell pairs, nibbles, whole boxes
    always_comb begin
        for (int s = 0; s < NSCALES; s++) begin
            lin[s] = '0;
            if (s == 0) begin
                lin[s].occ   = r_a_byte;
                lin[s].en    = '1;
                lin[s].fresh = 1'b1;
            end else begin
                lin[s].fresh = r_a_fresh[s];
                for (int k = 0; k < flag_cnt(s); k++) begin
                    lin[s].old[k] = r_rd[flag_off(s) + k];
                    lin[s].en[k]  = box_end[s];
                end
                if (s == 1) begin
                    for (int k = 0; k < 4; k++) begin
                        lin[s].occ[k] = |(r_a_byte & (PAIR_MASK << (2 * k)));
                    end
                end else if (s == 2) begin
                    for (int k = 0; k < 2; k++) begin
                        lin[s].occ[k] = |(r_a_byte & (NIBBLE_MASK << (4 * k)));
                    end
                end else begin
                    lin[s].occ[0] = r_or[s] | a_any;
                end
            end
        end
    end

    generate
        for (genvar g = 0; g < NSCALES; g++) begin : g_lane
            bic_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_fire  (a_fire),
                .i_clear (r_a_eof),
                .i_grp   (lin[g]),
                .o_flags (lane_flags[g]),
                .o_total (totals[g])
            );
        end
    endgenerate

    // merge: gather the lanes' flags into one memory row
    always_comb begin
        wdata = '0;
        for (int s = 1; s < NSCALES; s++) begin
            for (int k = 0; k < flag_cnt(s); k++) begin
                wdata[flag_off(s) + k] = lane_flags[s][k];
            end
        end
    end

    bic_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (a_fire && r_a_eof),
        .i_counts   (totals),
        .o_free     (emit_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

>>> rtl/bic_chk.sv
`default_nettype none
module bic_chk (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_s_tready,
    input wire logic                     o_m_tvalid,
    input wire logic                     i_m_tready,
    input wire logic [bic_pkg::OUT_W-1:0] o_m_tdata,
    input wire logic                     o_m_tlast
);
    import bic_pkg::*;

    // tlast only on the largest box size
    a_last_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[SCALE_W-1:0] == SCALE_W'(LOG_SIZE))))
        else $error("tlast does not match the largest scale");

    // scale never exceeds the largest box size
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[SCALE_W-1:0] <= SCALE_W'(LOG_SIZE)))
        else $error("scale out of range");

    // a run continues without a gap, one scale up
    a_run_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
        (o_m_tvalid && (o_m_tdata[SCALE_W-1:0] == $past(o_m_tdata[SCALE_W-1:0]) + 1'b1)))
        else $error("run of results broken");

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result beat changed");

    // the input only waits while results are still on offer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no results pending");

endmodule

bind binary_image_box_count bic_chk u_bic_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
